// ===== rtl/intel_hex_record_parser_macros.svh =====
// ---------------------------------------------------------------------------
// intel_hex_record_parser_macros.svh
// Assertion macros used by the record parser core, ihex_core.
// ---------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define IHEX_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ihex assertion failed");
// Condition must never be true outside reset.
`define IHEX_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ihex forbidden condition seen");
`else
`define IHEX_ASSERT(name, clk, rst_n, prop)
`define IHEX_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/ihex_pkg.sv =====
// ---------------------------------------------------------------------------
// ihex_pkg
// Types, codes and the hex digit decoder of the Intel HEX record parser.
// ---------------------------------------------------------------------------
package ihex_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned POS_W  = 10;  // 1 + up to 520 digits

  localparam logic [POS_W-1:0] POS_MAX = 10'd521;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  // Record types
  localparam logic [7:0] REC_DATA      = 8'd0;
  localparam logic [7:0] REC_EOF       = 8'd1;
  localparam logic [7:0] REC_EXT_SEG   = 8'd2;
  localparam logic [7:0] REC_START_SEG = 8'd3;
  localparam logic [7:0] REC_EXT_LIN   = 8'd4;
  localparam logic [7:0] REC_START_LIN = 8'd5;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_START    = 3'd1,
    ERR_DIGIT    = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECKSUM = 3'd4,
    ERR_TYPE     = 3'd5
  } err_e;

  typedef struct packed {
    logic              valid;
    logic              step;   // beat is processed this cycle
    logic [CHAR_W-1:0] character;
  } beat_t;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data_byte;
    logic [2:0]        record_type;
    logic [ADDR_W-1:0] entry_address;
    logic              entry_known;
    err_e              error_code;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [CHAR_W-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/ihex_in_stage.sv =====
// ---------------------------------------------------------------------------
// ihex_in_stage
// Input register: holds one character beat until the parser can take it.
// ---------------------------------------------------------------------------
module ihex_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ihex_pkg::CHAR_W-1:0] character_i,
  input  logic                        out_free_i,
  output ihex_pkg::beat_t             beat_o
);
  import ihex_pkg::*;

  logic              valid_q, valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              step;

  assign step       = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | step;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= character_i;
    end
  end

  assign beat_o.valid     = valid_q;
  assign beat_o.step      = step;
  assign beat_o.character = char_q;

endmodule

// ===== rtl/ihex_core.sv =====
// ---------------------------------------------------------------------------
// ihex_core
// Record state and per-character decode; produces at most one result a beat.
// ---------------------------------------------------------------------------
`include "intel_hex_record_parser_macros.svh"

module ihex_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ihex_pkg::beat_t beat_i,
  output ihex_pkg::res_t  res_o
);
  import ihex_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [3:0]        nib_q, nib_d;
  logic [7:0]        len_q, len_d;
  logic [15:0]       raddr_q, raddr_d;
  logic [7:0]        rkind_q, rkind_d;
  logic [7:0]        sum_q, sum_d;
  logic [31:0]       word_q, word_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] entry_q, entry_d;
  logic              eset_q, eset_d;
  logic              failed_q, failed_d;
  logic [ADDR_W-1:0] daddr_q, daddr_d;   // address of the next data byte

  logic [CHAR_W-1:0] c;
  hex_t              hx;
  logic              is_eol;
  logic [POS_W-1:0]  digits;
  logic [POS_W-1:0]  limit;
  logic [7:0]        value;
  logic [8:0]        bidx;
  logic [8:0]        idx;
  logic [15:0]       hi, lo;
  res_t              res;

  assign c      = beat_i.character;
  assign hx     = hex_decode(c);
  assign is_eol = (c == CHAR_CR) || (c == CHAR_LF);
  assign digits = pos_q - 10'd1;
  assign limit  = 10'd10 + {1'b0, len_q, 1'b0};
  assign value  = {nib_q, hx.value};
  assign bidx   = digits[POS_W-1:1];
  assign idx    = bidx - 9'd4;
  assign hi     = word_q[31:16];
  assign lo     = word_q[15:0];

  always_comb begin
    pos_d    = pos_q;
    nib_d    = nib_q;
    len_d    = len_q;
    raddr_d  = raddr_q;
    rkind_d  = rkind_q;
    sum_d    = sum_q;
    word_d   = word_q;
    base_d   = base_q;
    entry_d  = entry_q;
    eset_d   = eset_q;
    failed_d = failed_q;
    daddr_d  = daddr_q;

    res               = '0;
    res.kind          = KIND_DATA;
    res.error_code    = ERR_NONE;

    if (beat_i.step && !failed_q) begin
      if (is_eol) begin
        if (pos_q != '0) begin
          pos_d = '0;
          if (digits != limit) begin
            res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_LENGTH;
            failed_d  = 1'b1;
          end else if (sum_q != 8'd0) begin
            res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_CHECKSUM;
            failed_d  = 1'b1;
          end else if (rkind_q > REC_START_LIN) begin
            res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_TYPE;
            failed_d  = 1'b1;
          end else begin
            case (rkind_q)
              REC_EOF: begin
                if (!eset_q) begin
                  entry_d = {16'd0, raddr_q};
                  eset_d  = 1'b1;
                end
              end
              REC_EXT_SEG:   base_d = {12'd0, hi, 4'd0};
              REC_START_SEG: begin
                entry_d = {12'd0, hi, 4'd0} + {16'd0, lo};
                eset_d  = 1'b1;
              end
              REC_EXT_LIN:   base_d = {hi, 16'd0};
              REC_START_LIN: begin
                entry_d = word_q;
                eset_d  = 1'b1;
              end
              default: ;
            endcase
            res.valid         = 1'b1;
            res.kind          = KIND_RECORD;
            res.record_type   = rkind_q[2:0];
            res.entry_address = entry_d;
            res.entry_known   = eset_d;
          end
        end
      end else if (pos_q == '0) begin
        if (c != CHAR_COLON) begin
          res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_START;
          failed_d  = 1'b1;
        end else begin
          pos_d   = 10'd1;
          nib_d   = '0;
          len_d   = '0;
          raddr_d = '0;
          rkind_d = '0;
          sum_d   = '0;
          word_d  = '0;
        end
      end else if (!hx.ok) begin
        res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_DIGIT;
        failed_d  = 1'b1;
        pos_d     = '0;
      end else if (digits >= limit) begin
        res.valid = 1'b1;  res.kind = KIND_ERROR;  res.error_code = ERR_LENGTH;
        failed_d  = 1'b1;
        pos_d     = '0;
      end else begin
        pos_d = pos_q + 10'd1;
        if (!digits[0]) begin
          nib_d = hx.value;
        end else begin
          sum_d = sum_q + value;
          if (bidx == 9'd0) begin
            len_d = value;
          end else if (bidx == 9'd1) begin
            raddr_d = {value, 8'd0};
          end else if (bidx == 9'd2) begin
            raddr_d = {raddr_q[15:8], value};
            // base is fixed for the whole record, so the add happens once
            daddr_d = base_q + {16'd0, raddr_q[15:8], value};
          end else if (bidx == 9'd3) begin
            rkind_d = value;
          end else if (idx < {1'b0, len_q}) begin
            if (idx[8:2] == 7'd0) begin
              case (idx[1:0])
                2'd0:    word_d = word_q | {value, 24'd0};
                2'd1:    word_d = word_q | {8'd0, value, 16'd0};
                2'd2:    word_d = word_q | {16'd0, value, 8'd0};
                default: word_d = word_q | {24'd0, value};
              endcase
            end
            if (rkind_q == REC_DATA) begin
              res.valid     = 1'b1;
              res.kind      = KIND_DATA;
              res.address   = daddr_q;
              res.data_byte = value;
              daddr_d       = daddr_q + 32'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      nib_q    <= '0;
      len_q    <= '0;
      raddr_q  <= '0;
      rkind_q  <= '0;
      sum_q    <= '0;
      word_q   <= '0;
      base_q   <= '0;
      entry_q  <= '0;
      eset_q   <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      nib_q    <= nib_d;
      len_q    <= len_d;
      raddr_q  <= raddr_d;
      rkind_q  <= rkind_d;
      sum_q    <= sum_d;
      word_q   <= word_d;
      base_q   <= base_d;
      entry_q  <= entry_d;
      eset_q   <= eset_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    daddr_q <= daddr_d;
  end

  assign res_o = res;

  `IHEX_ASSERT(a_failed_sticky, clk_i, rst_ni, failed_q |=> failed_q)
  `IHEX_NEVER(a_no_result_failed, clk_i, rst_ni, failed_q && res.valid)
  `IHEX_ASSERT(a_error_sets_failed, clk_i, rst_ni, (res.valid && res.kind == KIND_ERROR) |=> failed_q)
  `IHEX_NEVER(a_pos_bound, clk_i, rst_ni, pos_q > POS_MAX)
  `IHEX_NEVER(a_result_without_beat, clk_i, rst_ni, res.valid && !beat_i.step)

endmodule

// ===== rtl/intel_hex_record_parser.sv =====
// ---------------------------------------------------------------------------
// intel_hex_record_parser: streaming Intel HEX decoder, one character a beat.
// Input and output are registered; 1 character/cycle unless output stalls.
// Async active-low reset clears offset, entry, error, record state but daddr.
// ---------------------------------------------------------------------------
module intel_hex_record_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ihex_pkg::CHAR_W-1:0] character_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [ihex_pkg::ADDR_W-1:0] address_o,
  output logic [7:0]                  data_byte_o,
  output logic [2:0]                  record_type_o,
  output logic [ihex_pkg::ADDR_W-1:0] entry_address_o,
  output logic                        entry_known_o,
  output logic [2:0]                  error_code_o
);
  import ihex_pkg::*;

  beat_t beat;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q, out_valid_d;
  logic  out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  ihex_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .out_free_i  (out_free),
    .beat_o      (beat)
  );

  ihex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (beat.step) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat.step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign address_o       = out_q.address;
  assign data_byte_o     = out_q.data_byte;
  assign record_type_o   = out_q.record_type;
  assign entry_address_o = out_q.entry_address;
  assign entry_known_o   = out_q.entry_known;
  assign error_code_o    = out_q.error_code;

endmodule

// ===== sim/tb_intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser
// Self-checking bench for the streaming Intel HEX record parser. A short table
// of characters runs first, then randomly built records of every type with
// random line ends, and one closing error that freezes the parser. Each output
// beat is compared with a bench-side tracker of the parser state.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  localparam int unsigned BODY_CHARS     = 1850;
  localparam int unsigned HOLD_OFF       = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct {
    kind_e       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  record_type;
    logic [31:0] entry_address;
    logic        entry_known;
    err_e        error_code;
  } parse_event_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        typed;
    kind_e       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  rtype;
    logic [31:0] entry;
    logic        known;
  } directed_row_t;

  // empty line, end-of-file record, one data byte at the top of the 16-bit range
  localparam directed_row_t DIRECTED [27] = '{
    '{CHAR_CR,    1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{CHAR_COLON, 1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"1",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"F",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"F",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{CHAR_LF,    1'b1, KIND_RECORD, 32'h0,      8'h00, 3'd1, 32'h0, 1'b1},
    '{CHAR_COLON, 1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"1",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"f",        1'b1, KIND_DATA,   32'h0000FFFF, 8'hFF, 3'd0, 32'h0, 1'b0},
    '{"0",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{"2",        1'b0, KIND_DATA,   32'h0,      8'h00, 3'd0, 32'h0, 1'b0},
    '{CHAR_LF,    1'b1, KIND_RECORD, 32'h0,      8'h00, 3'd0, 32'h0, 1'b1}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [31:0] address_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  record_type_o;
  logic [31:0] entry_address_o;
  logic        entry_known_o;
  logic [2:0]  error_code_o;

  intel_hex_record_parser dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .character_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .address_o,
    .data_byte_o,
    .record_type_o,
    .entry_address_o,
    .entry_known_o,
    .error_code_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // tracked parser state
  int unsigned pos;
  logic [3:0]  hi_nib;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  hdr_kind;
  logic [7:0]  rec_sum;
  logic [31:0] payload;
  logic [31:0] base_addr;
  logic [31:0] entry_addr;
  logic        entry_valid;
  logic        halted;

  parse_event_t awaited_events[$];
  int unsigned  mismatches   = 0;
  int unsigned  chars_fed    = 0;
  int unsigned  records_sent = 0;
  int unsigned  events_seen  = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  tx_calm      = 0;
  int unsigned  rx_calm      = 0;
  err_e         tail_err;

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c[3:0]);
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return int'(c[3:0]) + 9;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic parse_event_t blank_event(kind_e k);
    parse_event_t e;
    e.kind          = k;
    e.address       = '0;
    e.data_byte     = '0;
    e.record_type   = '0;
    e.entry_address = '0;
    e.entry_known   = 1'b0;
    e.error_code    = ERR_NONE;
    return e;
  endfunction

  function automatic parse_event_t halt_with(err_e code);
    parse_event_t e;
    halted = 1'b1;
    pos    = 0;
    e = blank_event(KIND_ERROR);
    e.error_code = code;
    return e;
  endfunction

  // Advances the tracked state by one accepted character.
  task automatic parse_step(input logic [7:0] c, output bit has, output parse_event_t ev);
    int          nib;
    int unsigned dig;
    int unsigned idx;
    logic [7:0]  val;
    has = 1'b0;
    ev  = blank_event(KIND_DATA);
    if (halted) return;
    if (c == CHAR_CR || c == CHAR_LF) begin
      if (pos == 0) return;
      has = 1'b1;
      dig = pos - 1;
      if (dig != 10 + 2 * rec_len) begin
        ev = halt_with(ERR_LENGTH);
        return;
      end
      if (rec_sum != 8'h00) begin
        ev = halt_with(ERR_CHECKSUM);
        return;
      end
      if (hdr_kind > REC_START_LIN) begin
        ev = halt_with(ERR_TYPE);
        return;
      end
      case (hdr_kind)
        REC_EOF: begin
          if (!entry_valid) begin
            entry_addr  = {16'h0, rec_addr};
            entry_valid = 1'b1;
          end
        end
        REC_EXT_SEG: base_addr = {12'h0, payload[31:16], 4'h0};
        REC_START_SEG: begin
          entry_addr  = {12'h0, payload[31:16], 4'h0} + {16'h0, payload[15:0]};
          entry_valid = 1'b1;
        end
        REC_EXT_LIN: base_addr = {payload[31:16], 16'h0};
        REC_START_LIN: begin
          entry_addr  = payload;
          entry_valid = 1'b1;
        end
        default: ;
      endcase
      pos = 0;
      ev = blank_event(KIND_RECORD);
      ev.record_type   = hdr_kind[2:0];
      ev.entry_address = entry_addr;
      ev.entry_known   = entry_valid;
      return;
    end
    if (pos == 0) begin
      if (c != CHAR_COLON) begin
        has = 1'b1;
        ev  = halt_with(ERR_START);
        return;
      end
      pos      = 1;
      hi_nib   = '0;
      rec_len  = '0;
      rec_addr = '0;
      hdr_kind = '0;
      rec_sum  = '0;
      payload  = '0;
      return;
    end
    nib = digit_value(c);
    if (nib < 0) begin
      has = 1'b1;
      ev  = halt_with(ERR_DIGIT);
      return;
    end
    dig = pos - 1;
    if (dig >= 10 + 2 * rec_len) begin
      has = 1'b1;
      ev  = halt_with(ERR_LENGTH);
      return;
    end
    pos++;
    if (dig[0] == 1'b0) begin
      hi_nib = nib[3:0];
      return;
    end
    val = {hi_nib, nib[3:0]};
    rec_sum += val;
    case (dig / 2)
      0: rec_len = val;
      1: rec_addr = {val, 8'h00};
      2: rec_addr[7:0] = val;
      3: hdr_kind = val;
      default: begin
        idx = dig / 2 - 4;
        if (idx < rec_len) begin
          if (idx < 4) payload |= {24'h0, val} << (24 - 8 * idx);
          if (hdr_kind == REC_DATA) begin
            has = 1'b1;
            ev.address   = base_addr + {16'h0, rec_addr} + idx;
            ev.data_byte = val;
          end
        end
      end
    endcase
  endtask

  // Called and returns at a falling edge; valid stays up into the next beat
  // when that one has no gap.
  task automatic drive_char(input logic [7:0] c);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_fed++;
    @(negedge clk_i);
  endtask

  task automatic feed_char(input logic [7:0] c);
    bit           has;
    parse_event_t ev;
    drive_char(c);
    parse_step(c, has, ev);
    if (has) awaited_events.push_back(ev);
  endtask

  task automatic finish_line();
    case ($urandom_range(0, 3))
      0: feed_char(CHAR_CR);
      1: feed_char(CHAR_LF);
      2: begin
        feed_char(CHAR_CR);
        feed_char(CHAR_LF);
      end
      default: begin
        feed_char(CHAR_LF);
        feed_char(CHAR_LF);
      end
    endcase
  endtask

  task automatic send_record(input logic [7:0] rtype, input int unsigned nbytes,
                             input logic [7:0] cksum_flip);
    logic [7:0] rec_bytes[$];
    logic [7:0] sum;
    rec_bytes = {8'(nbytes), pick_byte(), pick_byte(), rtype};
    repeat (nbytes) rec_bytes.push_back(pick_byte());
    sum = '0;
    foreach (rec_bytes[i]) sum += rec_bytes[i];
    rec_bytes.push_back((~sum + 8'd1) ^ cksum_flip);
    feed_char(CHAR_COLON);
    foreach (rec_bytes[i]) begin
      feed_char(hex_char(rec_bytes[i][7:4]));
      feed_char(hex_char(rec_bytes[i][3:0]));
    end
    finish_line();
    records_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // sender
  initial begin
    bit           has;
    parse_event_t ev;
    int unsigned  big_at;
    int unsigned  pick;
    int unsigned  n;
    logic [7:0]   c;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    character_i = '0;
    pos         = 0;
    hi_nib      = '0;
    rec_len     = '0;
    rec_addr    = '0;
    hdr_kind    = '0;
    rec_sum     = '0;
    payload     = '0;
    base_addr   = '0;
    entry_addr  = '0;
    entry_valid = 1'b0;
    halted      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      drive_char(DIRECTED[i].ch);
      parse_step(DIRECTED[i].ch, has, ev);
      if (DIRECTED[i].typed) begin
        ev = blank_event(DIRECTED[i].kind);
        ev.address       = DIRECTED[i].address;
        ev.data_byte     = DIRECTED[i].data_byte;
        ev.record_type   = DIRECTED[i].rtype;
        ev.entry_address = DIRECTED[i].entry;
        ev.entry_known   = DIRECTED[i].known;
        awaited_events.push_back(ev);
      end else if (has) begin
        awaited_events.push_back(ev);
      end
    end

    // mostly data records; one full-length record somewhere in the stream
    big_at = $urandom_range(5, 40);
    while (chars_fed < BODY_CHARS) begin
      pick = $urandom_range(0, 99);
      if (records_sent == big_at) send_record(REC_DATA, 255, 8'h00);
      else if (pick < 55) send_record(REC_DATA, $urandom_range(0, 16), 8'h00);
      else if (pick < 65) send_record(REC_EXT_LIN, $urandom_range(0, 6), 8'h00);
      else if (pick < 75) send_record(REC_EXT_SEG, $urandom_range(0, 6), 8'h00);
      else if (pick < 81) send_record(REC_START_SEG, $urandom_range(0, 6), 8'h00);
      else if (pick < 87) send_record(REC_START_LIN, $urandom_range(0, 6), 8'h00);
      else if (pick < 93) send_record(REC_EOF, $urandom_range(0, 3), 8'h00);
      else finish_line();
    end

    // one error ends the useful life of the parser
    tail_err = err_e'($urandom_range(1, 5));
    case (tail_err)
      ERR_START: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF || c == CHAR_COLON);
        feed_char(c);
      end
      ERR_DIGIT: begin
        feed_char(CHAR_COLON);
        n = $urandom_range(0, 8);
        repeat (n) feed_char(hex_char(4'($urandom_range(0, 15))));
        do c = 8'($urandom_range(0, 255));
        while (digit_value(c) >= 0 || c == CHAR_CR || c == CHAR_LF);
        feed_char(c);
      end
      ERR_LENGTH: begin
        feed_char(CHAR_COLON);
        if ($urandom_range(0, 1)) begin
          // short line
          n = $urandom_range(1, 9);
          repeat (n) feed_char(hex_char(4'($urandom_range(0, 15))));
          feed_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end else begin
          // one digit past the checksum of an empty record
          repeat (11) feed_char("0");
        end
      end
      ERR_CHECKSUM: begin
        send_record(8'($urandom_range(0, 5)), $urandom_range(0, 4),
                    8'($urandom_range(1, 255)));
      end
      default: send_record(8'($urandom_range(6, 255)), $urandom_range(0, 4), 8'h00);
    endcase
    feed_char(8'hFF);
    feed_char(8'h00);
    repeat (30) feed_char(8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("fed %0d characters in %0d records, checked %0d parser beats",
             chars_fed, records_sent, events_seen);
    $display("closing error case: %s", tail_err.name());
    if (mismatches == 0) begin
      $display("intel_hex_record_parser regression: pass");
    end else begin
      $display("intel_hex_record_parser regression: fail");
    end
    $finish;
  end

  // receiver
  initial begin
    parse_event_t want;
    int unsigned  gap;
    bit           held_off;
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held_off && events_seen >= 150) begin
        // long stall so the parser backs up into its input
        held_off = 1'b1;
        gap      = HOLD_OFF;
      end else begin
        gap = draw_wait(rx_calm);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      events_seen++;
      if (awaited_events.size() == 0) begin
        $error("unexpected beat: kind %0d address %0h data %0h", kind_o, address_o,
               data_byte_o);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("address", want.address, address_o);
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("record_type", want.record_type, record_type_o);
        check_field("entry_address", want.entry_address, entry_address_o);
        check_field("entry_known", want.entry_known, entry_known_o);
        check_field("error_code", want.error_code, error_code_o);
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("intel_hex_record_parser regression: fail");
      $finish;
    end
  end

endmodule
